// ===== rtl/core/ptaw_pkg.sv =====
package ptaw_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 32;
  localparam int unsigned AccW    = 32;
  localparam int unsigned ErrW    = SampleW + 1;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned FracW   = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegKp     = 4'd0,
    RegKiCoef = 4'd1,
    RegKdB    = 4'd2,
    RegKdA    = 4'd3,
    RegIntMax = 4'd4,
    RegIntMin = 4'd5,
    RegOutMax = 4'd6,
    RegOutMin = 4'd7
  } ptaw_reg_e;

  typedef struct packed {
    logic signed [CoefW-1:0]   kp;
    logic signed [CoefW-1:0]   ki_coef;
    logic signed [CoefW-1:0]   kd_b;
    logic signed [CoefW-1:0]   kd_a;
    logic signed [SampleW-1:0] int_max;
    logic signed [SampleW-1:0] int_min;
    logic signed [SampleW-1:0] out_max;
    logic signed [SampleW-1:0] out_min;
  } ptaw_cfg_t;

  typedef struct packed {
    logic signed [ErrW-1:0] last_error;
    logic signed [AccW-1:0] integral_acc;
    logic signed [AccW-1:0] deriv_acc;
    logic                   freeze_flag;
  } ptaw_state_t;

  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7fff;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

  localparam ptaw_cfg_t CfgReset = '{
    kp:      '0,
    ki_coef: '0,
    kd_b:    '0,
    kd_a:    '0,
    int_max: SampleMax,
    int_min: SampleMin,
    out_max: SampleMax,
    out_min: SampleMin
  };

endpackage

// ===== rtl/core/ptaw_if.sv =====
interface ptaw_in_if;
  import ptaw_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] setpoint;
  logic signed [SampleW-1:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface ptaw_out_if;
  import ptaw_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] drive;
  logic                      integral_held;

  modport source (output valid, output drive, output integral_held, input ready);
  modport sink   (input valid, input drive, input integral_held, output ready);
endinterface

interface ptaw_cfg_if;
  import ptaw_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CoefW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ptaw_datapath.sv =====
module ptaw_datapath (
  input  ptaw_pkg::ptaw_cfg_t                   cfg_i,
  input  ptaw_pkg::ptaw_state_t                 state_i,
  input  logic signed [ptaw_pkg::SampleW-1:0]   setpoint_i,
  input  logic signed [ptaw_pkg::SampleW-1:0]   measured_i,
  output ptaw_pkg::ptaw_state_t                 state_o,
  output logic signed [ptaw_pkg::SampleW-1:0]   drive_o,
  output logic                                  held_o
);
  import ptaw_pkg::*;

  localparam int unsigned DiffW  = ErrW + 1;
  localparam int unsigned ProdW  = CoefW + DiffW;
  localparam int unsigned IncW   = ProdW - 1;
  localparam int unsigned ISumW  = ProdW;
  localparam int unsigned FbW    = 2 * AccW;
  localparam int unsigned FbFlW  = FbW - FracW;
  localparam int unsigned DSumW  = ProdW + 1;
  localparam int unsigned KpW    = CoefW + ErrW;
  localparam int unsigned OSumW  = KpW + 2;
  localparam int unsigned YW     = OSumW - FracW;

  logic signed [ErrW-1:0]  err;
  logic signed [DiffW-1:0] esum;
  logic signed [DiffW-1:0] ediff;
  logic signed [AccW-1:0]  imax;
  logic signed [AccW-1:0]  imin;
  logic signed [ProdW-1:0] ki_prod;
  logic signed [IncW-1:0]  ki_inc;
  logic signed [ISumW-1:0] isum;
  logic                    opposite;
  logic                    inside_lim;
  logic signed [AccW-1:0]  integ_d;
  logic                    freeze_d;
  logic signed [ProdW-1:0] kd_prod;
  logic signed [FbW-1:0]   fb_prod;
  logic signed [FbFlW-1:0] fb_floor;
  logic signed [DSumW-1:0] dsum;
  logic signed [AccW-1:0]  deriv_d;
  logic signed [KpW-1:0]   kp_prod;
  logic signed [OSumW-1:0] osum;
  logic signed [YW-1:0]    y;

  assign err   = ErrW'(setpoint_i) - ErrW'(measured_i);
  assign esum  = DiffW'(err) + DiffW'(state_i.last_error);
  assign ediff = DiffW'(err) - DiffW'(state_i.last_error);
  assign imax  = {cfg_i.int_max, {FracW{1'b0}}};
  assign imin  = {cfg_i.int_min, {FracW{1'b0}}};

  assign ki_prod = ProdW'(cfg_i.ki_coef) * ProdW'(esum);
  assign ki_inc  = ki_prod[ProdW-1:1];
  assign isum    = ISumW'(state_i.integral_acc) + ISumW'(ki_inc);

  assign opposite = (err < 0 && state_i.integral_acc > 0) ||
                    (err > 0 && state_i.integral_acc < 0);
  assign inside_lim = (state_i.integral_acc < imax) && (state_i.integral_acc > imin);

  always_comb begin
    integ_d  = state_i.integral_acc;
    freeze_d = state_i.freeze_flag;
    if (cfg_i.ki_coef != 0) begin
      if (state_i.freeze_flag) begin
        if (opposite || inside_lim) begin
          freeze_d = 1'b0;
        end
      end else if (isum > ISumW'(imax)) begin
        integ_d  = imax;
        freeze_d = 1'b1;
      end else if (isum < ISumW'(imin)) begin
        integ_d  = imin;
        freeze_d = 1'b1;
      end else begin
        integ_d = isum[AccW-1:0];
      end
    end
  end

  assign kd_prod  = ProdW'(cfg_i.kd_b) * ProdW'(ediff);
  assign fb_prod  = FbW'(cfg_i.kd_a) * FbW'(state_i.deriv_acc);
  assign fb_floor = fb_prod[FbW-1:FracW];
  assign dsum     = DSumW'(kd_prod) - DSumW'(fb_floor);

  always_comb begin
    deriv_d = state_i.deriv_acc;
    if (cfg_i.kd_b != 0) begin
      if (dsum[DSumW-1:AccW-1] == '0 || dsum[DSumW-1:AccW-1] == '1) begin
        deriv_d = dsum[AccW-1:0];
      end else begin
        deriv_d = {dsum[DSumW-1], {(AccW-1){~dsum[DSumW-1]}}};
      end
    end
  end

  assign kp_prod = KpW'(cfg_i.kp) * KpW'(err);
  assign osum    = OSumW'(kp_prod) + OSumW'(integ_d) + OSumW'(deriv_d);
  assign y       = osum[OSumW-1:FracW];

  always_comb begin
    if (y > YW'(cfg_i.out_max)) begin
      drive_o = cfg_i.out_max;
    end else if (y < YW'(cfg_i.out_min)) begin
      drive_o = cfg_i.out_min;
    end else begin
      drive_o = y[SampleW-1:0];
    end
  end

  assign held_o               = freeze_d;
  assign state_o.last_error   = err;
  assign state_o.integral_acc = integ_d;
  assign state_o.deriv_acc    = deriv_d;
  assign state_o.freeze_flag  = freeze_d;

endmodule

// ===== rtl/core/pid_tustin_antiwindup_core.sv =====
// Channel  Role    Payload                          Transfer
// in_i     sink    setpoint, measured (s16 each)    valid && ready
// out_o    source  drive (s16), integral_held (1)   valid && ready
// cfg_i    sink    index (4), data (32)             valid && ready, always ready
//
// An input is taken into the input register, and its result into the output
// register with the new state; one item per cycle is sustained while out_o is ready.
// Reset clears the controller state and loads the default limits and gains.
// A stalled result holds in the output register; the input register still
// takes one more item and then holds it until the output drains.
module pid_tustin_antiwindup_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  ptaw_in_if.sink    in_i,
  ptaw_out_if.source out_o,
  ptaw_cfg_if.sink   cfg_i
);
  import ptaw_pkg::*;

  ptaw_cfg_t   cfg_q;
  ptaw_state_t state_q;
  ptaw_state_t state_d;

  logic                      in_valid_q;
  logic signed [SampleW-1:0] setpoint_q;
  logic signed [SampleW-1:0] measured_q;
  logic                      out_valid_q;
  logic signed [SampleW-1:0] drive_q;
  logic signed [SampleW-1:0] drive_d;
  logic                      held_q;
  logic                      held_d;
  logic                      advance;
  logic                      in_xfer;

  assign advance   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_xfer   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegKp:     cfg_q.kp      <= cfg_i.data;
        RegKiCoef: cfg_q.ki_coef <= cfg_i.data;
        RegKdB:    cfg_q.kd_b    <= cfg_i.data;
        RegKdA:    cfg_q.kd_a    <= cfg_i.data;
        RegIntMax: cfg_q.int_max <= cfg_i.data[SampleW-1:0];
        RegIntMin: cfg_q.int_min <= cfg_i.data[SampleW-1:0];
        RegOutMax: cfg_q.out_max <= cfg_i.data[SampleW-1:0];
        RegOutMin: cfg_q.out_min <= cfg_i.data[SampleW-1:0];
        default: ;
      endcase
    end
  end

  ptaw_datapath u_datapath (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .setpoint_i (setpoint_q),
    .measured_i (measured_q),
    .state_o    (state_d),
    .drive_o    (drive_d),
    .held_o     (held_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      setpoint_q <= in_i.setpoint;
      measured_q <= in_i.measured;
    end
    if (advance) begin
      drive_q <= drive_d;
      held_q  <= held_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.drive         = drive_q;
  assign out_o.integral_held = held_q;

endmodule

// ===== rtl/core/ptaw_checker.sv =====
module ptaw_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [ptaw_pkg::SampleW-1:0] drive_i,
  input logic                                integral_held_i
);

  // a rising result always follows an input transfer
  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without matching input transfer");

  // no result after a reset edge
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result shown during reset");

  // an input is always taken while no result is pending
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && $past(!out_valid_i) |-> in_ready_i)
    else $error("input blocked with empty output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_i) &&
                                    $stable(integral_held_i))
    else $error("stalled result changed");

endmodule

bind pid_tustin_antiwindup_core ptaw_checker u_ptaw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .drive_i         (out_o.drive),
  .integral_held_i (out_o.integral_held)
);

// ===== test/tb_pid_tustin_antiwindup_core.sv =====
module tb_pid_tustin_antiwindup_core;
  import ptaw_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic signed [SampleW-1:0] setpoint;
    logic signed [SampleW-1:0] measured;
  } sample_t;

  typedef struct packed {
    logic signed [SampleW-1:0] drive;
    logic                      held;
  } ctrl_out_t;

  logic clk_i;
  logic rst_ni;

  ptaw_in_if  in_if ();
  ptaw_out_if out_if ();
  ptaw_cfg_if cfg_if ();

  pid_tustin_antiwindup_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  sample_t   sample_q[$];
  ctrl_out_t pending_drive_q[$];

  int errors;
  int samples_queued;
  int drives_seen;
  int cycle_cnt;
  int long_hold_req;
  int long_hold_done;

  ptaw_cfg_t                 ctl_cfg;
  logic signed [ErrW-1:0]    prev_err;
  logic signed [AccW-1:0]    integ;
  logic signed [AccW-1:0]    deriv;
  logic                      frozen;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic ctrl_out_t step_controller(logic signed [SampleW-1:0] sp,
                                                logic signed [SampleW-1:0] ms);
    longint err, prev, imax, imin, sum, dv, acc, y, cur;
    logic opposite, inside_lim;
    ctrl_out_t res;
    err  = longint'(sp) - longint'(ms);
    prev = longint'(prev_err);
    imax = longint'($signed(ctl_cfg.int_max)) * 65536;
    imin = longint'($signed(ctl_cfg.int_min)) * 65536;
    cur  = longint'(integ);
    if (ctl_cfg.ki_coef != '0) begin
      if (frozen) begin
        opposite   = (err < 0 && cur > 0) || (err > 0 && cur < 0);
        inside_lim = (cur < imax) && (cur > imin);
        if (opposite || inside_lim) frozen = 1'b0;
      end else begin
        sum = cur + ((longint'($signed(ctl_cfg.ki_coef)) * (err + prev)) >>> 1);
        if (sum > imax) begin
          sum    = imax;
          frozen = 1'b1;
        end else if (sum < imin) begin
          sum    = imin;
          frozen = 1'b1;
        end
        integ = sum[AccW-1:0];
      end
    end
    if (ctl_cfg.kd_b != '0) begin
      dv = longint'($signed(ctl_cfg.kd_b)) * (err - prev)
         - ((longint'($signed(ctl_cfg.kd_a)) * longint'(deriv)) >>> 16);
      if (dv > 64'sd2147483647) dv = 64'sd2147483647;
      if (dv < -64'sd2147483648) dv = -64'sd2147483648;
      deriv = dv[AccW-1:0];
    end
    acc = longint'($signed(ctl_cfg.kp)) * err + longint'(integ) + longint'(deriv);
    y = acc >>> 16;
    if (y > longint'($signed(ctl_cfg.out_max))) y = longint'($signed(ctl_cfg.out_max));
    else if (y < longint'($signed(ctl_cfg.out_min))) y = longint'($signed(ctl_cfg.out_min));
    prev_err  = err[ErrW-1:0];
    res.drive = y[SampleW-1:0];
    res.held  = frozen;
    return res;
  endfunction

  function automatic logic signed [SampleW-1:0] sat16(int v);
    if (v > 32767) return SampleMax;
    if (v < -32768) return SampleMin;
    return v[SampleW-1:0];
  endfunction

  function automatic logic [CoefW-1:0] pick_gain();
    logic [CoefW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = 32'h7fff_ffff;
      2: v = 32'h8000_0000;
      3, 4: v = $urandom_range(0, 32'h0001_8000);
      5: v = $urandom_range(0, 32'h0040_0000);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1) && v != 32'h8000_0000) v = -v;
    return v;
  endfunction

  task automatic pick_limits(output logic [CoefW-1:0] hi, output logic [CoefW-1:0] lo);
    int a, b;
    a = $signed(16'($urandom));
    b = $signed(16'($urandom));
    case ($urandom_range(0, 4))
      0: begin
        hi = 32'(SampleMax);
        lo = 32'(SampleMin);
      end
      1: begin
        hi = 32'(a < b ? a : b);
        lo = 32'(a < b ? b : a);
      end
      2, 3: begin
        hi = 32'($urandom_range(0, 3000));
        lo = -32'($urandom_range(0, 3000));
      end
      default: begin
        hi = 32'(a < b ? b : a);
        lo = 32'(a < b ? a : b);
      end
    endcase
  endtask

  task automatic cfg_write(input ptaw_reg_e idx, input logic [CoefW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      RegKp:     ctl_cfg.kp      = val;
      RegKiCoef: ctl_cfg.ki_coef = val;
      RegKdB:    ctl_cfg.kd_b    = val;
      RegKdA:    ctl_cfg.kd_a    = val;
      RegIntMax: ctl_cfg.int_max = val[SampleW-1:0];
      RegIntMin: ctl_cfg.int_min = val[SampleW-1:0];
      RegOutMax: ctl_cfg.out_max = val[SampleW-1:0];
      RegOutMin: ctl_cfg.out_min = val[SampleW-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic cfg_all(input logic [CoefW-1:0] kp, input logic [CoefW-1:0] ki,
                         input logic [CoefW-1:0] kdb, input logic [CoefW-1:0] kda,
                         input logic [CoefW-1:0] imax, input logic [CoefW-1:0] imin,
                         input logic [CoefW-1:0] omax, input logic [CoefW-1:0] omin);
    cfg_write(RegKp, kp);
    cfg_write(RegKiCoef, ki);
    cfg_write(RegKdB, kdb);
    cfg_write(RegKdA, kda);
    cfg_write(RegIntMax, imax);
    cfg_write(RegIntMin, imin);
    cfg_write(RegOutMax, omax);
    cfg_write(RegOutMin, omin);
  endtask

  task automatic push_sample(input logic signed [SampleW-1:0] sp,
                             input logic signed [SampleW-1:0] ms);
    sample_t s;
    s.setpoint = sp;
    s.measured = ms;
    sample_q.push_back(s);
    samples_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (drives_seen < samples_queued);
  endtask

  task automatic queue_random_samples(input int n);
    int left, seg, mode, base, meas;
    left = n;
    while (left > 0) begin
      seg  = $urandom_range(4, 40);
      if (seg > left) seg = left;
      left -= seg;
      mode = $urandom_range(0, 4);
      base = $signed(16'($urandom));
      meas = $signed(16'($urandom));
      repeat (seg) begin
        case (mode)
          0: push_sample(16'($urandom), 16'($urandom));
          1, 2: begin
            // step response: measured creeps towards setpoint
            push_sample(sat16(base), sat16(meas));
            meas = meas + (base - meas) / 4 + int'($urandom_range(0, 40)) - 20;
          end
          3: push_sample(sat16(base + $urandom_range(0, 64) - 32), sat16(base));
          default: begin
            base = $urandom_range(0, 3);
            meas = $urandom_range(0, 3);
            push_sample(base == 0 ? SampleMax : base == 1 ? SampleMin : 16'(base - 2),
                        meas == 0 ? SampleMax : meas == 1 ? SampleMin : 16'(meas - 2));
          end
        endcase
      end
    end
  endtask

  // sender: bursts and gaps
  int burst_left;
  int gap_left;

  always @(posedge clk_i) begin
    sample_t s;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      burst_left  = 4;
      gap_left    = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pending_drive_q.push_back(step_controller(in_if.setpoint, in_if.measured));
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          s = sample_q.pop_front();
          in_if.valid    <= 1'b1;
          in_if.setpoint <= s.setpoint;
          in_if.measured <= s.measured;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern, checking
  int        rx_mode;
  int        rx_mode_left;
  int        rx_hold_left;
  logic [15:0] rx_pattern;

  always @(posedge clk_i) begin
    ctrl_out_t want;
    logic      rdy;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_mode      = 0;
      rx_mode_left = 50;
      rx_hold_left = 0;
      rx_pattern   = 16'hffff;
    end else begin
      if (out_if.valid && out_if.ready) begin
        drives_seen++;
        if (pending_drive_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer drive=%0d integral_held=%0b",
                   $time, out_if.drive, out_if.integral_held);
        end else begin
          want = pending_drive_q.pop_front();
          if (out_if.drive !== want.drive) begin
            errors++;
            $display("%0t: drive expected %0d got %0d", $time, want.drive, out_if.drive);
          end
          if (out_if.integral_held !== want.held) begin
            errors++;
            $display("%0t: integral_held expected %0b got %0b",
                     $time, want.held, out_if.integral_held);
          end
        end
      end
      if (long_hold_req != long_hold_done) begin
        long_hold_done = long_hold_req;
        rx_hold_left   = 120;
      end
      rx_mode_left--;
      if (rx_mode_left <= 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(40, 120);
        rx_pattern   = $urandom;
      end
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = $urandom_range(0, 1);
        2: rdy = rx_pattern[cycle_cnt % 16];
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        rdy = 1'b0;
      end
      out_if.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.setpoint  = '0;
    in_if.measured  = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    errors          = 0;
    samples_queued  = 0;
    drives_seen     = 0;
    cycle_cnt       = 0;
    long_hold_req   = 0;
    long_hold_done  = 0;
    ctl_cfg         = CfgReset;
    prev_err        = '0;
    integ           = '0;
    deriv           = '0;
    frozen          = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset gains and limits
    push_sample(SampleMax, SampleMin);
    push_sample(SampleMin, SampleMax);
    push_sample(16'sd0, 16'sd0);
    wait_drained();

    // clamp high, hold, release on opposite sign, clamp low, hold
    cfg_all(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 32'hffff_8000,
            32'd1000, -32'sd1000, 32'd20000, -32'sd20000);
    push_sample(SampleMax, 16'sd0);
    push_sample(16'sd100, 16'sd0);
    push_sample(-16'sd50, 16'sd0);
    push_sample(SampleMin, SampleMax);
    push_sample(16'sd0, 16'sd0);
    wait_drained();

    // release with the integral strictly inside widened limits
    cfg_write(RegIntMin, -32'sd2000);
    push_sample(16'sd5, 16'sd5);
    push_sample(16'sd0, 16'sd0);
    wait_drained();

    // extreme gains, crossed limits, derivative saturation
    cfg_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
            -32'sd100, 32'd100, -32'sd5, 32'd5);
    push_sample(SampleMax, SampleMin);
    push_sample(SampleMin, SampleMax);
    push_sample(SampleMax, SampleMin);
    push_sample(16'sd0, 16'sd0);
    push_sample(-16'sd1, 16'sd0);
    wait_drained();

    // integral and derivative held
    cfg_all(32'hffff_0000, 32'h0, 32'h0, 32'h0001_0000,
            32'(SampleMax), 32'(SampleMin), 32'(SampleMax), 32'(SampleMin));
    push_sample(16'sd1234, -16'sd4321);
    push_sample(SampleMin, SampleMin);
    push_sample(SampleMax, SampleMax);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      logic [CoefW-1:0] ihi, ilo, ohi, olo;
      pick_limits(ihi, ilo);
      pick_limits(ohi, olo);
      cfg_all(pick_gain(), pick_gain(), pick_gain(), pick_gain(), ihi, ilo, ohi, olo);
      queue_random_samples(190);
      if (ph == 3) long_hold_req++;
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (pending_drive_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_drive_q.size());
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
